// ===== design/ttwv_pkg.sv =====
// ----------------------------------------------------------------------------
// ttwv_pkg
// Shared constants and the arctangent table of the wind vector core.
// ----------------------------------------------------------------------------
package ttwv_pkg;

    localparam int TIME_W  = 24;
    localparam int SCALE_W = 20;
    localparam int AXIS_W  = 18;
    localparam int DIR_W   = 16;

    localparam logic [23:0] MILLION    = 24'd1000000;
    localparam logic [16:0] AXIS_LIMIT = 17'd100000;

    // atan(2^-i) in 1/256 hundredth of a degree
    function automatic logic [20:0] atan_lut(input logic [4:0] i);
        logic [20:0] v;
        begin
            unique case (i)
                5'd0:    v = 21'd1152000;
                5'd1:    v = 21'd680065;
                5'd2:    v = 21'd359328;
                5'd3:    v = 21'd182400;
                5'd4:    v = 21'd91554;
                5'd5:    v = 21'd45822;
                5'd6:    v = 21'd22916;
                5'd7:    v = 21'd11459;
                5'd8:    v = 21'd5730;
                5'd9:    v = 21'd2865;
                5'd10:   v = 21'd1432;
                5'd11:   v = 21'd716;
                5'd12:   v = 21'd358;
                5'd13:   v = 21'd179;
                5'd14:   v = 21'd90;
                5'd15:   v = 21'd45;
                5'd16:   v = 21'd22;
                5'd17:   v = 21'd11;
                5'd18:   v = 21'd6;
                5'd19:   v = 21'd3;
                default: v = 21'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== design/ttwv_axis.sv =====
// ----------------------------------------------------------------------------
// ttwv_axis
// One axis component: 1e6*scale*|tb-tf|/(tf*tb), one shared multiplier and a
// bit-serial restoring divider, saturated and signed.
// ----------------------------------------------------------------------------
module ttwv_axis (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [19:0]         scale,
    input  logic [23:0]         tf,
    input  logic [23:0]         tb,
    output logic                done,
    output logic signed [17:0]  mag
);

    typedef enum logic [2:0] {IDLE, MUL_P, MUL_D, MUL_NL, MUL_NH, CHECK, DIVIDE, FINISH}
        state_t;

    state_t       state_reg;
    logic [23:0]  tf_reg, tb_reg, d_reg;
    logic         neg_reg, sat_reg;
    logic [43:0]  p_reg;
    logic [47:0]  den_reg;
    logic [63:0]  n_reg;
    logic [48:0]  rem_reg;
    logic [16:0]  low_reg, q_reg;
    logic [4:0]   cnt_reg;

    logic [23:0]  mul_a, mul_b;
    logic [47:0]  prod;
    logic [48:0]  rem_next;
    logic         ge;
    logic [16:0]  mag_u;

    always_comb
    begin
        unique case (state_reg)
            MUL_P:   begin mul_a = {4'd0, scale};       mul_b = d_reg; end
            MUL_NL:  begin mul_a = {2'd0, p_reg[21:0]}; mul_b = ttwv_pkg::MILLION; end
            MUL_NH:  begin mul_a = {2'd0, p_reg[43:22]}; mul_b = ttwv_pkg::MILLION; end
            default: begin mul_a = tf_reg;              mul_b = tb_reg; end
        endcase
        prod     = mul_a * mul_b;
        rem_next = {rem_reg[47:0], low_reg[16]};
        ge       = rem_next >= {1'b0, den_reg};
        if (sat_reg || q_reg > ttwv_pkg::AXIS_LIMIT)
            mag_u = ttwv_pkg::AXIS_LIMIT;
        else
            mag_u = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= state_reg == FINISH;
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        tf_reg    <= tf;
                        tb_reg    <= tb;
                        d_reg     <= (tb > tf) ? tb - tf : tf - tb;
                        neg_reg   <= tb < tf;
                        sat_reg   <= 1'b0;
                        q_reg     <= '0;
                        state_reg <= MUL_P;
                    end
                end
                MUL_P:
                begin
                    p_reg     <= prod[43:0];
                    state_reg <= MUL_D;
                end
                MUL_D:
                begin
                    den_reg   <= prod;
                    state_reg <= MUL_NL;
                end
                MUL_NL:
                begin
                    n_reg     <= {16'd0, prod};
                    state_reg <= MUL_NH;
                end
                MUL_NH:
                begin
                    n_reg     <= n_reg + {prod[41:0], 22'd0};
                    state_reg <= CHECK;
                end
                CHECK:
                begin
                    if ({1'b0, n_reg[63:17]} >= den_reg)
                    begin
                        sat_reg   <= 1'b1;
                        state_reg <= FINISH;
                    end
                    else
                    begin
                        rem_reg   <= {2'd0, n_reg[63:17]};
                        low_reg   <= n_reg[16:0];
                        cnt_reg   <= 5'd16;
                        state_reg <= DIVIDE;
                    end
                end
                DIVIDE:
                begin
                    rem_reg <= ge ? rem_next - {1'b0, den_reg} : rem_next;
                    q_reg   <= {q_reg[15:0], ge};
                    low_reg <= {low_reg[15:0], 1'b0};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_reg <= FINISH;
                end
                FINISH:
                begin
                    mag       <= neg_reg ? -$signed({1'b0, mag_u}) : $signed({1'b0, mag_u});
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

// ===== design/ttwv_isqrt.sv =====
// ----------------------------------------------------------------------------
// ttwv_isqrt
// Wind speed: squares of both components, then a two-bits-per-step root.
// ----------------------------------------------------------------------------
module ttwv_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [17:0] x,
    input  logic signed [17:0] y,
    output logic               done,
    output logic [17:0]        root
);

    typedef enum logic [2:0] {IDLE, SQ_X, SQ_Y, ROOT, FINISH} state_t;

    state_t      state_reg;
    logic [17:0] ax_reg, ay_reg;
    logic [35:0] v_reg;
    logic [20:0] r_reg;
    logic [17:0] q_reg;
    logic [4:0]  cnt_reg;

    logic [17:0] mul_a;
    logic [35:0] prod;
    logic [20:0] r_try, t_try;
    logic        ge;

    always_comb
    begin
        mul_a = (state_reg == SQ_Y) ? ay_reg : ax_reg;
        prod  = mul_a * mul_a;
        r_try = {r_reg[18:0], v_reg[35:34]};
        t_try = {1'b0, q_reg, 2'b01};
        ge    = r_try >= t_try;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= state_reg == FINISH;
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        ax_reg    <= x[17] ? 18'(-x) : 18'(x);
                        ay_reg    <= y[17] ? 18'(-y) : 18'(y);
                        state_reg <= SQ_X;
                    end
                end
                SQ_X:
                begin
                    v_reg     <= prod;
                    state_reg <= SQ_Y;
                end
                SQ_Y:
                begin
                    v_reg     <= v_reg + prod;
                    r_reg     <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= 5'd17;
                    state_reg <= ROOT;
                end
                ROOT:
                begin
                    r_reg   <= ge ? r_try - t_try : r_try;
                    q_reg   <= {q_reg[16:0], ge};
                    v_reg   <= {v_reg[33:0], 2'b00};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_reg <= FINISH;
                end
                FINISH:
                begin
                    root      <= q_reg;
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

// ===== design/ttwv_cordic.sv =====
// ----------------------------------------------------------------------------
// ttwv_cordic
// Direction: vectoring CORDIC, one iteration per cycle, quadrant restore.
// ----------------------------------------------------------------------------
module ttwv_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [17:0] x,
    input  logic signed [17:0] y,
    output logic               done,
    output logic signed [15:0] dir
);

    typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

    state_t             state_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [24:0] z_reg;
    logic [4:0]         i_reg;
    logic               xneg_reg, yneg_reg, xz_reg, yz_reg;

    logic [16:0]        ax, ay;
    logic signed [33:0] sx, sy;
    logic signed [24:0] step_z, zr;
    logic [13:0]        a;
    logic signed [15:0] r;

    always_comb
    begin
        ax     = x[17] ? 17'(-x) : x[16:0];
        ay     = y[17] ? 17'(-y) : y[16:0];
        sx     = cx_reg >>> i_reg;
        sy     = cy_reg >>> i_reg;
        step_z = $signed({4'd0, ttwv_pkg::atan_lut(i_reg)});
        zr     = (z_reg + 25'sd128) >>> 8;
        priority if (xz_reg)
            a = 14'd9000;
        else if (yz_reg || z_reg < 0)
            a = 14'd0;
        else if (zr > 25'sd9000)
            a = 14'd9000;
        else
            a = zr[13:0];
        if (xz_reg && yz_reg)
            r = 16'sd0;
        else if (!xneg_reg)
            r = yneg_reg ? -$signed({2'b0, a}) : $signed({2'b0, a});
        else
            r = yneg_reg ? $signed({2'b0, a}) - 16'sd18000
                         : 16'sd18000 - $signed({2'b0, a});
        if (r == -16'sd18000)
            r = 16'sd18000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= state_reg == FINISH;
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        cx_reg    <= $signed({3'd0, ax, 14'd0});
                        cy_reg    <= $signed({3'd0, ay, 14'd0});
                        z_reg     <= '0;
                        i_reg     <= '0;
                        xneg_reg  <= x[17];
                        yneg_reg  <= y[17];
                        xz_reg    <= ax == 17'd0;
                        yz_reg    <= ay == 17'd0;
                        state_reg <= (ax == 17'd0 || ay == 17'd0) ? FINISH : RUN;
                    end
                end
                RUN:
                begin
                    if (cy_reg > 0)
                    begin
                        cx_reg <= cx_reg + sy;
                        cy_reg <= cy_reg - sx;
                        z_reg  <= z_reg + step_z;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - sy;
                        cy_reg <= cy_reg + sx;
                        z_reg  <= z_reg - step_z;
                    end
                    i_reg <= i_reg + 5'd1;
                    if (i_reg == 5'd19)
                        state_reg <= FINISH;
                end
                FINISH:
                begin
                    dir       <= r;
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

// ===== design/transit_time_wind_vector_core.sv =====
// ----------------------------------------------------------------------------
// transit_time_wind_vector_core
// Two-axis transit-time anemometer: wind components, speed and direction.
// ----------------------------------------------------------------------------
// Input request on s_axis: four flight times in ns. Output request on m_axis:
// wind_x, wind_y, wind_speed, wind_direction in tdata, fresh in tuser.
// path_scale must be written through cfg_we/cfg_wdata only while the core
// is idle; the core itself does not enforce this. s_axis_tready is high
// only while the sequencer is idle; one request is worked at a time. A valid
// measurement runs two axis passes (4 multiplies + 17 divide steps; divide
// steps are skipped when the quotient saturates early), the squares and
// root, the CORDIC (iterations skipped when a component is zero) and one
// output load. s_axis_tready and m_axis_tvalid then rise in the same cycle.
// A request with a zero time or zero scale runs only the CORDIC on the held
// vector (no iterations when a held component is zero), with fresh = 0.
// The result waits in an output register; if the receiver stalls, the next
// request is still accepted and worked, and its result waits, with
// s_axis_tready low, until the register frees.
// Reset clears path_scale, the held vector and speed, and the output valid.
// ----------------------------------------------------------------------------
module transit_time_wind_vector_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // time_x_forward, time_y_forward, time_x_backward, time_y_backward
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // wind_x, wind_y, wind_speed, wind_direction, 2'b0 pad
    output logic [71:0] m_axis_tdata,
    // fresh
    output logic        m_axis_tuser
);

    typedef enum logic [2:0] {IDLE, AXIS_X, AXIS_Y, SPEED, DIRECTION, RESULT} state_t;

    state_t             state_reg;
    logic [19:0]        scale_reg;
    logic [23:0]        txf_reg, tyf_reg, txb_reg, tyb_reg;
    logic signed [17:0] wx_reg, held_x_reg, held_y_reg;
    logic [17:0]        held_s_reg;
    logic               fresh_reg;
    logic               axis_go_reg, sqrt_go_reg, dir_go_reg;
    logic [71:0]        tdata_reg;
    logic               tuser_reg, mvalid_reg;

    logic               accept, valid_meas;
    logic [23:0]        axis_tf, axis_tb;
    logic               axis_done, sqrt_done, dir_done;
    logic signed [17:0] axis_mag;
    logic [17:0]        root;
    logic signed [15:0] dir;

    assign s_axis_tready = state_reg == IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign valid_meas    = scale_reg != '0 && s_axis_tdata[23:0] != '0 &&
                           s_axis_tdata[47:24] != '0 && s_axis_tdata[71:48] != '0 &&
                           s_axis_tdata[95:72] != '0;
    assign axis_tf       = (state_reg == AXIS_Y) ? tyf_reg : txf_reg;
    assign axis_tb       = (state_reg == AXIS_Y) ? tyb_reg : txb_reg;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

    ttwv_axis u_axis (
        .clk   (clk),
        .rst_n (rst_n),
        .start (axis_go_reg),
        .scale (scale_reg),
        .tf    (axis_tf),
        .tb    (axis_tb),
        .done  (axis_done),
        .mag   (axis_mag)
    );

    ttwv_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_go_reg),
        .x     (wx_reg),
        .y     (axis_mag),
        .done  (sqrt_done),
        .root  (root)
    );

    ttwv_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dir_go_reg),
        .x     (held_x_reg),
        .y     (held_y_reg),
        .done  (dir_done),
        .dir   (dir)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            scale_reg   <= '0;
            held_x_reg  <= '0;
            held_y_reg  <= '0;
            held_s_reg  <= '0;
            axis_go_reg <= 1'b0;
            sqrt_go_reg <= 1'b0;
            dir_go_reg  <= 1'b0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            axis_go_reg <= (accept && valid_meas) || (state_reg == AXIS_X && axis_done);
            sqrt_go_reg <= state_reg == AXIS_Y && axis_done;
            dir_go_reg  <= (accept && !valid_meas) || (state_reg == SPEED && sqrt_done);
            if (cfg_we)
                scale_reg <= cfg_wdata;
            if (state_reg == RESULT && (!mvalid_reg || m_axis_tready))
                mvalid_reg <= 1'b1;
            else if (mvalid_reg && m_axis_tready)
                mvalid_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        txf_reg   <= s_axis_tdata[23:0];
                        tyf_reg   <= s_axis_tdata[47:24];
                        txb_reg   <= s_axis_tdata[71:48];
                        tyb_reg   <= s_axis_tdata[95:72];
                        fresh_reg <= valid_meas;
                        if (valid_meas)
                            state_reg <= AXIS_X;
                        else
                            state_reg <= DIRECTION;
                    end
                end
                AXIS_X:
                begin
                    if (axis_done)
                    begin
                        wx_reg    <= axis_mag;
                        state_reg <= AXIS_Y;
                    end
                end
                AXIS_Y:
                begin
                    if (axis_done)
                    begin
                        held_y_reg <= axis_mag;
                        state_reg  <= SPEED;
                    end
                end
                SPEED:
                begin
                    if (sqrt_done)
                    begin
                        held_x_reg <= wx_reg;
                        held_s_reg <= root;
                        state_reg  <= DIRECTION;
                    end
                end
                DIRECTION:
                begin
                    if (dir_done)
                        state_reg <= RESULT;
                end
                RESULT:
                begin
                    if (!mvalid_reg || m_axis_tready)
                    begin
                        tdata_reg <= {2'b00, dir, held_s_reg, held_y_reg, held_x_reg};
                        tuser_reg <= fresh_reg;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule
